>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Checks are compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst, expr, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/ils_pkg.sv
// ---------------------------------------------------------------------------
// ils_pkg
// Types and constants of the integer literal scanner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

  localparam int ACC_W         = 64;
  localparam int PROD_W        = ACC_W + 4;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ZERO,
    PH_SCAN
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_BIN,
    RADIX_OCT
  } radix_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A_LC   = 8'h61;
  localparam logic [7:0] CH_F_LC   = 8'h66;
  localparam logic [7:0] CH_A_UC   = 8'h41;
  localparam logic [7:0] CH_F_UC   = 8'h46;
  localparam logic [7:0] CH_E_LC   = 8'h65;
  localparam logic [7:0] CH_E_UC   = 8'h45;
  localparam logic [7:0] CH_X_LC   = 8'h78;
  localparam logic [7:0] CH_X_UC   = 8'h58;
  localparam logic [7:0] CH_B_LC   = 8'h62;
  localparam logic [7:0] CH_B_UC   = 8'h42;
  localparam logic [7:0] CH_O_LC   = 8'h6f;
  localparam logic [7:0] CH_O_UC   = 8'h4f;
  localparam logic [7:0] CH_P_LC   = 8'h70;
  localparam logic [7:0] CH_P_UC   = 8'h50;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_USCORE = 8'h5f;

  // classified source byte, as queued between front and back
  typedef struct packed {
    logic       start;
    logic       is_dec;
    logic       is_hex_alpha;
    logic       is_expo;
    logic       is_uscore;
    logic       has_prefix;
    radix_t     prefix;
    logic       is_dot;
    logic       is_pmark;
    logic [3:0] digit;
    logic [7:0] raw;
  } cls_item_t;

endpackage

`default_nettype wire

>>> rtl/ils_front.sv
// ---------------------------------------------------------------------------
// ils_front
// Classifies each incoming source byte: digit value, prefix letters,
// underscore and float markers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ils_front
  import ils_pkg::*;
(
  input  wire logic [7:0] source_byte,
  input  wire logic       literal_start,
  output cls_item_t       item
);

  logic [7:0] dec_off;
  logic [7:0] lc_off;
  logic [7:0] uc_off;
  logic       lc_hex;
  logic       uc_hex;

  always_comb begin
    dec_off = source_byte - CH_ZERO;
    lc_off  = source_byte - CH_A_LC;
    uc_off  = source_byte - CH_A_UC;
    lc_hex  = (source_byte >= CH_A_LC) && (source_byte <= CH_F_LC);
    uc_hex  = (source_byte >= CH_A_UC) && (source_byte <= CH_F_UC);

    item              = '0;
    item.start        = literal_start;
    item.raw          = source_byte;
    item.is_dec       = (source_byte >= CH_ZERO) && (source_byte <= CH_NINE);
    item.is_hex_alpha = lc_hex || uc_hex;
    item.is_expo      = (source_byte == CH_E_LC) || (source_byte == CH_E_UC);
    item.is_uscore    = (source_byte == CH_USCORE);
    item.is_dot       = (source_byte == CH_DOT);
    item.is_pmark     = (source_byte == CH_P_LC) || (source_byte == CH_P_UC);

    if (item.is_dec) begin
      item.digit = dec_off[3:0];
    end else if (lc_hex) begin
      item.digit = lc_off[3:0] + 4'd10;
    end else if (uc_hex) begin
      item.digit = uc_off[3:0] + 4'd10;
    end

    unique case (source_byte) inside
      CH_X_LC, CH_X_UC: begin
        item.has_prefix = 1'b1;
        item.prefix     = RADIX_HEX;
      end
      CH_B_LC, CH_B_UC: begin
        item.has_prefix = 1'b1;
        item.prefix     = RADIX_BIN;
      end
      CH_O_LC, CH_O_UC: begin
        item.has_prefix = 1'b1;
        item.prefix     = RADIX_OCT;
      end
      default: begin
        item.has_prefix = 1'b0;
        item.prefix     = RADIX_DEC;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/ils_queue.sv
// ---------------------------------------------------------------------------
// ils_queue
// Short FIFO of classified items between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ils_queue
  import ils_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire cls_item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output cls_item_t      pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_HOLDS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count above depth")
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count did not rise")
  `ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == $past(count) - 1'b1, "queue count did not fall")

endmodule

`default_nettype wire

>>> rtl/ils_back.sv
// ---------------------------------------------------------------------------
// ils_back
// Scan state machine: accumulates digits in the selected base, checks
// underscores and overflow, and registers one result per literal ended by a stop byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ils_back
  import ils_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire cls_item_t         item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ACC_W-1:0]       literal_value,
  output logic [1:0]             literal_status,
  output logic [1:0]             radix_code,
  output logic [7:0]             stop_byte,
  output logic                   float_follows
);

  phase_t             phase, phase_next;
  radix_t             radix, radix_next;
  logic [ACC_W-1:0]   accum, accum_next;
  logic [1:0]         status, status_next;
  logic               prev_us, prev_us_next;
  logic               any_seen, any_seen_next;

  // digit unit
  logic [ACC_W-1:0]   eff_acc;
  radix_t             eff_radix;
  logic [1:0]         eff_status;
  logic [PROD_W-1:0]  wide_acc;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  sum;
  logic               digit_bad;
  logic [ACC_W-1:0]   add_acc;
  logic [1:0]         add_status;

  logic               scan_end;
  logic               emit_req;
  logic               advance;
  logic               emit;
  logic [1:0]         fin_status;
  logic [ACC_W-1:0]   fin_value;
  logic               fin_float;

  // a fresh literal starts from zero in decimal
  always_comb begin
    eff_acc    = item.start ? '0 : accum;
    eff_radix  = item.start ? RADIX_DEC : radix;
    eff_status = item.start ? ST_OK : status;
    wide_acc   = {4'b0, eff_acc};

    unique case (eff_radix)
      RADIX_DEC: begin
        prod      = (wide_acc << 3) + (wide_acc << 1);
        digit_bad = (item.digit > 4'd9);
      end
      RADIX_HEX: begin
        prod      = wide_acc << 4;
        digit_bad = 1'b0;
      end
      RADIX_BIN: begin
        prod      = wide_acc << 1;
        digit_bad = (item.digit > 4'd1);
      end
      RADIX_OCT: begin
        prod      = wide_acc << 3;
        digit_bad = (item.digit > 4'd7);
      end
      default: begin
        prod      = '0;
        digit_bad = 1'b0;
      end
    endcase

    sum        = prod + PROD_W'(item.digit);
    add_acc    = eff_acc;
    add_status = digit_bad ? ST_INVALID : eff_status;
    if (add_status == ST_OK) begin
      if (sum[PROD_W-1:ACC_W] == '0) begin
        add_acc = sum[ACC_W-1:0];
      end else begin
        add_status = ST_OVERFLOW;
      end
    end
  end

  // does this item close the literal?
  always_comb begin
    scan_end = ((radix != RADIX_HEX) && item.is_expo) ||
               !(item.is_hex_alpha || item.is_dec || item.is_uscore);
    emit_req = !item.start &&
               (((phase == PH_ZERO) && !item.is_dec && !item.has_prefix) ||
                ((phase == PH_SCAN) && scan_end));
    item_ready = !emit_req || !out_valid || out_ready;
    advance    = item_valid && item_ready;
  end

  always_comb begin
    phase_next    = phase;
    radix_next    = radix;
    accum_next    = accum;
    status_next   = status;
    prev_us_next  = prev_us;
    any_seen_next = any_seen;
    emit          = 1'b0;

    fin_status = (phase == PH_SCAN && prev_us) ? ST_INVALID : status;
    unique case (fin_status)
      ST_OK:       fin_value = accum;
      ST_OVERFLOW: fin_value = '1;
      default:     fin_value = '0;
    endcase
    fin_float = (((radix == RADIX_DEC) || (radix == RADIX_HEX)) && item.is_dot) ||
                ((radix == RADIX_DEC) && item.is_expo) ||
                ((radix == RADIX_HEX) && item.is_pmark);

    if (advance) begin
      if (item.start) begin
        if (!item.is_dec) begin
          phase_next = PH_IDLE;
        end else begin
          radix_next   = RADIX_DEC;
          prev_us_next = 1'b0;
          if (item.digit == 4'd0) begin
            phase_next    = PH_ZERO;
            accum_next    = '0;
            status_next   = ST_OK;
            any_seen_next = 1'b0;
          end else begin
            phase_next    = PH_SCAN;
            accum_next    = add_acc;
            status_next   = add_status;
            any_seen_next = 1'b1;
          end
        end
      end else begin
        unique case (phase)
          PH_ZERO: begin
            if (item.is_dec) begin
              phase_next    = PH_SCAN;
              accum_next    = add_acc;
              status_next   = add_status;
              any_seen_next = 1'b1;
              prev_us_next  = 1'b0;
            end else if (item.has_prefix) begin
              phase_next = PH_SCAN;
              radix_next = item.prefix;
            end else begin
              emit       = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          PH_SCAN: begin
            if (scan_end) begin
              emit        = 1'b1;
              status_next = fin_status;
              phase_next  = PH_IDLE;
            end else if (item.is_uscore) begin
              if (!any_seen || prev_us) begin
                status_next = ST_INVALID;
              end
              prev_us_next  = 1'b1;
              any_seen_next = 1'b1;
            end else begin
              accum_next    = add_acc;
              status_next   = add_status;
              any_seen_next = 1'b1;
              prev_us_next  = 1'b0;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      radix    <= RADIX_DEC;
      accum    <= '0;
      status   <= ST_OK;
      prev_us  <= 1'b0;
      any_seen <= 1'b0;
    end else begin
      phase    <= phase_next;
      radix    <= radix_next;
      accum    <= accum_next;
      status   <= status_next;
      prev_us  <= prev_us_next;
      any_seen <= any_seen_next;
    end
  end

  // result register: refilled in the same cycle it is drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      literal_value  <= fin_value;
      literal_status <= fin_status;
      radix_code     <= radix;
      stop_byte      <= item.raw;
      float_follows  <= fin_float;
    end
  end

  `ASSERT_IMPLY(a_zero_clean, clk, rst, phase == PH_ZERO, (accum == '0) && (status == ST_OK) && (radix == RADIX_DEC), "leading zero phase with stale state")
  `ASSERT_IMPLY(a_status_code, clk, rst, out_valid, literal_status != 2'd3, "undefined status code")
  `ASSERT_IMPLY(a_invalid_zero, clk, rst, out_valid && (literal_status == ST_INVALID), literal_value == '0, "invalid result with non-zero value")
  `ASSERT_IMPLY(a_ovf_ones, clk, rst, out_valid && (literal_status == ST_OVERFLOW), literal_value == '1, "overflow result not saturated")

endmodule

`default_nettype wire

>>> rtl/integer_literal_scanner.sv
// ---------------------------------------------------------------------------
// integer_literal_scanner
// Scans integer literals with optional 0x/0b/0o prefix, one byte per item.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue has room; the back end
// holds a stop byte while an earlier result is still unread. The digit step
// is a shift-add of the accumulator done combinationally by the back-end
// state machine. The stop byte is queued, then the back end registers the result.
// Reset (rst, synchronous): empties the queue, drops any pending result
// and returns the scanner to idle in decimal with a zero accumulator.
`timescale 1ns / 1ps
`default_nettype none

module integer_literal_scanner
  import ils_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        source_byte,
  input  wire logic              literal_start,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ACC_W-1:0]       literal_value,
  output logic [1:0]             literal_status,
  output logic [1:0]             radix_code,
  output logic [7:0]             stop_byte,
  output logic                   float_follows
);

  cls_item_t front_item;
  cls_item_t back_item;
  logic      back_valid;
  logic      back_ready;

  ils_front u_front (
    .source_byte   (source_byte),
    .literal_start (literal_start),
    .item          (front_item)
  );

  ils_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  ils_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (back_valid),
    .item_ready     (back_ready),
    .item           (back_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .literal_value  (literal_value),
    .literal_status (literal_status),
    .radix_code     (radix_code),
    .stop_byte      (stop_byte),
    .float_follows  (float_follows)
  );

endmodule

`default_nettype wire

>>> tb/tb_integer_literal_scanner.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_integer_literal_scanner
// Self-checking bench for the integer literal scanner. Source bytes are sent
// one per item. A scan model inside the bench predicts each literal result,
// and every result is checked field by field in order. Directed literals
// come first. Random literals follow, run under several sender and receiver
// idling mixes. The random literals use all four radixes and values near
// the overflow limit, with underscores, bad digits, abandoned literals and
// noise bytes mixed in.
// ---------------------------------------------------------------------------

module tb_integer_literal_scanner;
  import ils_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 14;

  typedef struct {
    logic [ACC_W-1:0] value;
    logic [1:0]       status;
    radix_t           radix;
    logic [7:0]       stop;
    logic             flt;
  } lit_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        source_byte = 8'h00;
  logic              literal_start = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ACC_W-1:0]  literal_value;
  logic [1:0]        literal_status;
  logic [1:0]        radix_code;
  logic [7:0]        stop_byte;
  logic              float_follows;

  // scan model state
  phase_t            sc_phase = PH_IDLE;
  radix_t            sc_radix = RADIX_DEC;
  logic [ACC_W-1:0]  sc_acc   = '0;
  logic [1:0]        sc_err   = ST_OK;
  logic              sc_under = 1'b0;
  logic              sc_seen  = 1'b0;

  lit_result_t       pending_results[$];
  lit_result_t       head_result;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int bytes_accepted  = 0;
  int bytes_scanned   = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int unexpected_count = 0;
  int idle_cycles     = 0;
  int status_count[3] = '{0, 0, 0};

  integer_literal_scanner DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .source_byte   (source_byte),
    .literal_start (literal_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .literal_value (literal_value),
    .literal_status(literal_status),
    .radix_code    (radix_code),
    .stop_byte     (stop_byte),
    .float_follows (float_follows)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------ model

  function automatic logic [ACC_W-1:0] base_of(input radix_t r);
    case (r)
      RADIX_HEX: return 64'd16;
      RADIX_BIN: return 64'd2;
      RADIX_OCT: return 64'd8;
      default:   return 64'd10;
    endcase
  endfunction

  function automatic bit is_dec_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void take_digit(input logic [ACC_W-1:0] d);
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] thr;
    logic [ACC_W-1:0] rem;
    base = base_of(sc_radix);
    thr  = {ACC_W{1'b1}} / base;
    rem  = {ACC_W{1'b1}} % base;
    sc_seen  = 1'b1;
    sc_under = 1'b0;
    if (d >= base) sc_err = ST_INVALID;
    if (sc_err == ST_OK) begin
      if (sc_acc < thr || (sc_acc == thr && d <= rem)) sc_acc = sc_acc * base + d;
      else sc_err = ST_OVERFLOW;
    end
  endfunction

  function automatic void close_literal(input logic [7:0] c);
    lit_result_t r;
    r.value  = (sc_err == ST_OK) ? sc_acc : (sc_err == ST_OVERFLOW) ? '1 : '0;
    r.status = sc_err;
    r.radix  = sc_radix;
    r.stop   = c;
    r.flt    = ((sc_radix == RADIX_DEC || sc_radix == RADIX_HEX) && c == CH_DOT) ||
               (sc_radix == RADIX_DEC && (c == CH_E_LC || c == CH_E_UC)) ||
               (sc_radix == RADIX_HEX && (c == CH_P_LC || c == CH_P_UC));
    pending_results.push_back(r);
    sc_phase = PH_IDLE;
  endfunction

  // returns 0 when the block merely ignores the byte
  function automatic bit scan_byte(input logic [7:0] c, input logic st);
    if (st) begin
      if (!is_dec_char(c)) begin
        sc_phase = PH_IDLE;
        return 1'b0;
      end
      sc_radix = RADIX_DEC;
      sc_acc   = '0;
      sc_err   = ST_OK;
      sc_under = 1'b0;
      sc_seen  = 1'b0;
      if (c == CH_ZERO) begin
        sc_phase = PH_ZERO;
      end else begin
        sc_phase = PH_SCAN;
        take_digit(ACC_W'(c - CH_ZERO));
      end
      return 1'b1;
    end
    if (sc_phase == PH_ZERO) begin
      if (is_dec_char(c)) begin
        sc_phase = PH_SCAN;
        take_digit(ACC_W'(c - CH_ZERO));
      end else if (c == CH_X_LC || c == CH_X_UC) begin
        sc_radix = RADIX_HEX;
        sc_phase = PH_SCAN;
      end else if (c == CH_B_LC || c == CH_B_UC) begin
        sc_radix = RADIX_BIN;
        sc_phase = PH_SCAN;
      end else if (c == CH_O_LC || c == CH_O_UC) begin
        sc_radix = RADIX_OCT;
        sc_phase = PH_SCAN;
      end else begin
        close_literal(c);
      end
      return 1'b1;
    end
    if (sc_phase == PH_SCAN) begin
      // exponent mark ends the literal below base 16
      if (sc_radix != RADIX_HEX && (c == CH_E_LC || c == CH_E_UC)) begin
        if (sc_under) sc_err = ST_INVALID;
        close_literal(c);
      end else if (c >= CH_A_LC && c <= CH_F_LC) begin
        take_digit(ACC_W'(c - CH_A_LC + 8'd10));
      end else if (c >= CH_A_UC && c <= CH_F_UC) begin
        take_digit(ACC_W'(c - CH_A_UC + 8'd10));
      end else if (is_dec_char(c)) begin
        take_digit(ACC_W'(c - CH_ZERO));
      end else if (c == CH_USCORE) begin
        if (!sc_seen || sc_under) sc_err = ST_INVALID;
        sc_under = 1'b1;
        sc_seen  = 1'b1;
      end else begin
        if (sc_under) sc_err = ST_INVALID;
        close_literal(c);
      end
      return 1'b1;
    end
    sc_phase = PH_IDLE;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    source_byte   <= b;
    literal_start <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_accepted++;
    if (scan_byte(b, st)) bytes_scanned++;
  endtask

  // first character carries the start flag
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // ------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        unexpected_count++;
        if (unexpected_count + mismatch_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected: value %h status %0d stop %h",
                   $realtime, literal_value, literal_status, stop_byte);
      end else begin
        head_result = pending_results.pop_front();
        results_checked++;
        if (literal_status < 3) status_count[literal_status]++;
        if (literal_value !== head_result.value || literal_status !== head_result.status ||
            radix_code !== head_result.radix || stop_byte !== head_result.stop ||
            float_follows !== head_result.flt) begin
          mismatch_count++;
          if (unexpected_count + mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch exp value %h st %0d radix %0d stop %h flt %0b, got %h %0d %0d %h %0b",
                     $realtime, head_result.value, head_result.status, head_result.radix,
                     head_result.stop, head_result.flt, literal_value, literal_status,
                     radix_code, stop_byte, float_follows);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("integer_literal_scanner test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------ tests

  task automatic test_radix_prefixes();
    send_text("0x1fP");   // hex, binary exponent follows
    send_text("0B1_0.");  // binary, dot is no fraction here
    send_text("0o9 ");    // digit above octal range
    send_text("7e");      // decimal exponent follows
  endtask

  task automatic test_literal_edge_cases();
    send_text("05.");     // leading zero then digit stays decimal
    send_text("0_");      // zero then anything else ends at once
    send_text("0x");      // bare prefix, end of source
    send_item(8'h00, 1'b0);
    send_text("1__2_,");  // doubled and trailing underscore
    send_item(CH_A_LC, 1'b1);  // start on a letter is dropped
    send_item(8'hFF, 1'b0);    // idle byte
    send_text("8");       // abandoned by the next start
    send_text("6)");
  endtask

  task automatic test_random_literals(input int s_idle, input int r_stall, input int n_items);
    logic [7:0]       text[$];
    logic [7:0]       digs[$];
    logic [ACC_W-1:0] v;
    logic [ACC_W-1:0] base;
    logic [7:0]       d;
    radix_t           r;
    int               mode;
    int               first;
    string            stop_set;
    stop_set = ". eEpP;),+x";
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    first = bytes_scanned;
    while (bytes_scanned - first < n_items) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 3))
          send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        text.delete();
        digs.delete();
        r    = radix_t'($urandom_range(3));
        base = base_of(r);
        mode = $urandom_range(99);
        if (mode < 40) v = ACC_W'($urandom_range(999));
        else if (mode < 65) v = {$urandom, $urandom} >> $urandom_range(63);
        else v = '1 - ACC_W'($urandom_range(20));
        do begin
          digs.push_front(8'(v % base));
          v = v / base;
        end while (v != 0);
        // one digit too many pushes near-limit values over
        if (mode >= 85) digs.push_back(8'($urandom_range(int'(base) - 1)));
        if (r != RADIX_DEC || $urandom_range(3) == 0) text.push_back(CH_ZERO);
        case (r)
          RADIX_HEX: text.push_back($urandom_range(1) ? CH_X_UC : CH_X_LC);
          RADIX_BIN: text.push_back($urandom_range(1) ? CH_B_UC : CH_B_LC);
          RADIX_OCT: text.push_back($urandom_range(1) ? CH_O_UC : CH_O_LC);
          default: ;
        endcase
        if (r != RADIX_DEC && $urandom_range(19) == 0) digs.delete();
        if (text.size() != 0 && $urandom_range(29) == 0) text.push_back(CH_USCORE);
        foreach (digs[i]) begin
          if (i > 0 && $urandom_range(9) == 0) begin
            text.push_back(CH_USCORE);
            if ($urandom_range(9) == 0) text.push_back(CH_USCORE);
          end
          d = digs[i];
          if ($urandom_range(49) == 0) d = 8'($urandom_range(15));
          if (d < 8'd10) text.push_back(CH_ZERO + d);
          else text.push_back(($urandom_range(1) ? CH_A_UC : CH_A_LC) + d - 8'd10);
        end
        if ($urandom_range(29) == 0) text.push_back(CH_USCORE);
        if ($urandom_range(24) == 0) begin
          // cut short: the next start abandons it
          while (text.size() > 1 && $urandom_range(2) != 0) void'(text.pop_back());
        end else if ($urandom_range(9) < 7) begin
          text.push_back(stop_set[$urandom_range(stop_set.len() - 1)]);
        end else begin
          text.push_back(8'($urandom_range(255)));
        end
        foreach (text[i]) send_item(text[i], i == 0);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_radix_prefixes();
    test_literal_edge_cases();
    wait_drained();
    test_random_literals(0, 0, 475);
    test_random_literals(64, 0, 475);
    test_random_literals(0, 64, 475);
    test_random_literals(7, 7, 475);
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d bytes sent, %0d scanned; %0d results checked (%0d ok, %0d invalid, %0d overflow)",
             bytes_accepted, bytes_scanned, results_checked, status_count[0],
             status_count[1], status_count[2]);
    $display("random literals ran with sender/receiver idling of 0/0, 64/0, 0/64 and 7/7 percent");
    if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0) begin
      $display("integer_literal_scanner test passed");
    end else begin
      $display("%0d mismatches, %0d unexpected results", mismatch_count, unexpected_count);
      $display("integer_literal_scanner test failed");
    end
    $finish;
  end

endmodule
